>>> hdl/tcw_pkg.sv
// Shared constants and types for the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  // Payload widths fixed by the interface.
  localparam int MODE_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int CELL_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_PUT         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCROLL_UP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCROLL_DOWN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ        = 3'd4;

  // Character codes with special meaning in put mode.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Attribute after reset.
  localparam logic [7:0] RESET_ATTR = 8'h07;

  // Register word index of the attribute register.
  localparam logic ATTR_REG = 1'b0;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COPY = 5'b00010,
    S_FILL = 5'b00100,
    S_READ = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

>>> hdl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/text_console_writer_top.sv
// Top level of the text console writer: screen memory, cursor and operation sequencer.
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  ----------------------------------------------
//   input     in         in_valid / in_ready  mode, char_code, cell_index
//   output    out        out_valid/out_ready  cursor_row, cursor_col, read_char, read_attribute
//   config    in/out     APB psel/penable     paddr, pwdata, prdata (text_attribute)
//
// A put or backspace, a newline above the bottom row, an unused mode or a read outside the
// screen goes straight to the done state; a cell read on the screen also passes through the
// read state, needed for the registered read of the screen RAM. A scroll, including one
// started by a newline on the bottom row or by writing the last cell, moves one cell per cycle
// through the single RAM read port. A clear writes one cell per cycle.
// After reset the block sweeps the screen to blank cells before it raises in_ready; register
// writes are taken during that sweep.
// A finished result waits in the output register, and the next transaction is taken meanwhile;
// the sequencer only stalls at the end of that next transaction if the result is still held.
module text_console_writer_top #(
  parameter int COLS = tcw_pkg::COLS_DEFAULT,
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tcw_pkg::MODE_W-1:0]        mode,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]       cell_index,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0]     cursor_col,
  output logic [tcw_pkg::CHAR_W-1:0]        read_char,
  output logic [tcw_pkg::CHAR_W-1:0]        read_attribute,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  // Screen geometry derived from the parameters.
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [AW-1:0]    LAST_CELL    = AW'(CELLS - 1);
  localparam logic [AW-1:0]    LAST_ROW_POS = AW'(CELLS - COLS);
  localparam logic [AW-1:0]    COLS_A       = AW'(COLS);
  localparam logic [CNT_W-1:0] CELLS_CNT    = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] COPY_CNT     = CNT_W'(CELLS - COLS);
  localparam logic [CNT_W-1:0] COLS_CNT     = CNT_W'(COLS);
  localparam logic [RW-1:0]    LAST_ROW     = RW'(ROWS - 1);
  localparam logic [CW-1:0]    LAST_COL     = CW'(COLS - 1);
  localparam logic [31:0]      CELLS32      = 32'(CELLS);

  tcw_pkg::state_t state;

  // Cursor kept both as row/column and as a linear cell address.
  logic [AW-1:0] cur_pos;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;

  logic [7:0] text_attribute;

  // Sweep engine: source and destination addresses, count left and direction.
  logic [AW-1:0]    src;
  logic [AW-1:0]    dst;
  logic [CNT_W-1:0] cnt;
  logic             dir_down;
  logic             init_pass;
  // Copy pipeline: a read issued last cycle returns data for this destination.
  logic             cp_valid;
  logic [AW-1:0]    cp_dst;

  // Read results of the current transaction.
  logic [tcw_pkg::CHAR_W-1:0] res_char;
  logic [tcw_pkg::CHAR_W-1:0] res_attr;

  // RAM port signals.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic                       in_fire;
  logic                       out_free;
  logic                       cfg_write;
  logic                       read_in_range;
  logic [tcw_pkg::CELL_W-1:0] blank_cell;
  logic [tcw_pkg::CELL_W-1:0] reset_cell;
  logic [AW-1:0]              step;

  assign in_ready      = (state == tcw_pkg::S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_free      = !out_valid || out_ready;
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready
                         && (paddr[2] == tcw_pkg::ATTR_REG);
  assign read_in_range = ({21'd0, cell_index} < CELLS32);
  assign blank_cell    = {text_attribute, tcw_pkg::CH_SPACE};
  assign reset_cell    = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
  // Sweeps walk up through the memory, or down for a scroll down.
  assign step          = dir_down ? {AW{1'b1}} : AW'(1);

  // Register reads return the attribute, other words read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == tcw_pkg::ATTR_REG) begin
      prdata = {24'd0, text_attribute};
    end
  end

  // RAM port selection. Only one state drives the write port in any cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst;
    ram_wdata = blank_cell;
    ram_raddr = src;
    case (state)
      tcw_pkg::S_IDLE: begin
        ram_raddr = AW'(cell_index);
        if (in_fire && mode == tcw_pkg::MODE_PUT) begin
          if (char_code == tcw_pkg::CH_BACKSPACE) begin
            // Blank the cell left of the cursor unless already at the first cell.
            ram_we    = (cur_pos != '0);
            ram_waddr = cur_pos - AW'(1);
            ram_wdata = blank_cell;
          end else if (char_code != tcw_pkg::CH_NEWLINE) begin
            ram_we    = 1'b1;
            ram_waddr = cur_pos;
            ram_wdata = {text_attribute, char_code};
          end
        end
      end
      tcw_pkg::S_COPY: begin
        ram_we    = cp_valid;
        ram_waddr = cp_dst;
        ram_wdata = ram_rdata;
      end
      tcw_pkg::S_FILL: begin
        ram_we    = (cnt != '0);
        ram_waddr = dst;
        ram_wdata = init_pass ? reset_cell : blank_cell;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::RESET_ATTR;
    end else if (cfg_write) begin
      text_attribute <= pwdata[7:0];
    end
  end

  // Sequencer, cursor and sweep engine. Reset starts a blanking sweep over the whole screen.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::S_FILL;
      init_pass <= 1'b1;
      dst       <= '0;
      cnt       <= CELLS_CNT;
      dir_down  <= 1'b0;
      cp_valid  <= 1'b0;
      cur_pos   <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
    end else begin
      case (state)
        tcw_pkg::S_IDLE: begin
          if (in_fire) begin
            res_char <= '0;
            res_attr <= '0;
            state    <= tcw_pkg::S_DONE;
            case (mode)
              tcw_pkg::MODE_PUT: begin
                if (char_code == tcw_pkg::CH_NEWLINE) begin
                  if (cur_row == LAST_ROW) begin
                    // Newline on the bottom row scrolls the screen up.
                    src      <= COLS_A;
                    dst      <= '0;
                    cnt      <= COPY_CNT;
                    dir_down <= 1'b0;
                    cur_pos  <= LAST_ROW_POS;
                    cur_col  <= '0;
                    state    <= tcw_pkg::S_COPY;
                  end else begin
                    cur_pos <= cur_pos - AW'(cur_col) + COLS_A;
                    cur_row <= cur_row + RW'(1);
                    cur_col <= '0;
                  end
                end else if (char_code == tcw_pkg::CH_BACKSPACE) begin
                  if (cur_pos != '0) begin
                    cur_pos <= cur_pos - AW'(1);
                    if (cur_col == '0) begin
                      cur_col <= LAST_COL;
                      cur_row <= cur_row - RW'(1);
                    end else begin
                      cur_col <= cur_col - CW'(1);
                    end
                  end
                end else if (cur_pos == LAST_CELL) begin
                  // Writing the last cell runs off the screen: scroll up after the write.
                  src      <= COLS_A;
                  dst      <= '0;
                  cnt      <= COPY_CNT;
                  dir_down <= 1'b0;
                  cur_pos  <= LAST_ROW_POS;
                  cur_col  <= '0;
                  state    <= tcw_pkg::S_COPY;
                end else begin
                  cur_pos <= cur_pos + AW'(1);
                  if (cur_col == LAST_COL) begin
                    cur_col <= '0;
                    cur_row <= cur_row + RW'(1);
                  end else begin
                    cur_col <= cur_col + CW'(1);
                  end
                end
              end
              tcw_pkg::MODE_CLEAR: begin
                dst       <= '0;
                cnt       <= CELLS_CNT;
                dir_down  <= 1'b0;
                init_pass <= 1'b0;
                cur_pos   <= '0;
                cur_row   <= '0;
                cur_col   <= '0;
                state     <= tcw_pkg::S_FILL;
              end
              tcw_pkg::MODE_SCROLL_UP: begin
                src      <= COLS_A;
                dst      <= '0;
                cnt      <= COPY_CNT;
                dir_down <= 1'b0;
                cur_pos  <= LAST_ROW_POS;
                cur_row  <= LAST_ROW;
                cur_col  <= '0;
                state    <= tcw_pkg::S_COPY;
              end
              tcw_pkg::MODE_SCROLL_DOWN: begin
                src      <= LAST_CELL - COLS_A;
                dst      <= LAST_CELL;
                cnt      <= COPY_CNT;
                dir_down <= 1'b1;
                cur_pos  <= '0;
                cur_row  <= '0;
                cur_col  <= '0;
                state    <= tcw_pkg::S_COPY;
              end
              tcw_pkg::MODE_READ: begin
                // The RAM read was issued this cycle; data arrives in the read state.
                if (read_in_range) begin
                  state <= tcw_pkg::S_READ;
                end
              end
              default: begin
                state <= tcw_pkg::S_DONE;
              end
            endcase
          end
        end
        tcw_pkg::S_COPY: begin
          // One read per cycle, written back in the following cycle. Reads always lie ahead of the
          // writes in the sweep direction, so no cell is read after it was overwritten.
          cp_valid <= (cnt != '0);
          cp_dst   <= dst;
          if (cnt != '0) begin
            src <= src + step;
            dst <= dst + step;
            cnt <= cnt - CNT_W'(1);
          end else if (!cp_valid) begin
            // The destination now points at the row to blank, in the same direction.
            init_pass <= 1'b0;
            cnt       <= COLS_CNT;
            state     <= tcw_pkg::S_FILL;
          end
        end
        tcw_pkg::S_FILL: begin
          if (cnt != '0) begin
            dst <= dst + step;
            cnt <= cnt - CNT_W'(1);
          end else begin
            init_pass <= 1'b0;
            state     <= init_pass ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
          end
        end
        tcw_pkg::S_READ: begin
          res_char <= ram_rdata[7:0];
          res_attr <= ram_rdata[15:8];
          state    <= tcw_pkg::S_DONE;
        end
        tcw_pkg::S_DONE: begin
          if (out_free) begin
            state <= tcw_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tcw_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded once the operation is done and the previous result has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcw_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcw_pkg::S_DONE && out_free) begin
      cursor_row     <= tcw_pkg::ROW_OUT_W'(cur_row);
      cursor_col     <= tcw_pkg::COL_OUT_W'(cur_col);
      read_char      <= res_char;
      read_attribute <= res_attr;
    end
  end

endmodule
